/* sv/pid_with_twiddle_tuning_top_assert.svh */
// Assertion macros shared by the controller modules.
`ifndef PID_WITH_TWIDDLE_TUNING_TOP_ASSERT_SVH
`define PID_WITH_TWIDDLE_TUNING_TOP_ASSERT_SVH

`ifndef SYNTH
`define PWTT_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
`define PWTT_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define PWTT_ASSERT_IMPL(lbl, ante, cons, msg)
`define PWTT_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

/* sv/pwtt_pkg.sv */
package pwtt_pkg;

	typedef enum logic [2:0] {
		REG_KP     = 3'd0,
		REG_KI     = 3'd1,
		REG_KD     = 3'd2,
		REG_STEP_P = 3'd3,
		REG_STEP_D = 3'd4,
		REG_STEP_I = 3'd5,
		REG_BEST   = 3'd6,
		REG_RUN    = 3'd7
	} reg_index_t;

	localparam logic signed [31:0] RST_KP     = 32'sd0;
	localparam logic signed [31:0] RST_KI     = 32'sd0;
	localparam logic signed [31:0] RST_KD     = 32'sd0;
	localparam logic [30:0]        RST_STEP_P = 31'd167772;
	localparam logic [30:0]        RST_STEP_D = 31'd1677722;
	localparam logic [30:0]        RST_STEP_I = 31'd4194;
	localparam logic signed [15:0] RST_BEST   = 16'sd256;
	localparam logic [15:0]        RST_RUN    = 16'd200;

	typedef struct packed {
		logic signed [31:0] kp;
		logic signed [31:0] ki;
		logic signed [31:0] kd;
		logic [30:0]        step_p;
		logic [30:0]        step_d;
		logic [30:0]        step_i;
		logic signed [15:0] best;
		logic [15:0]        run_len;
	} cfg_regs_t;

	// operands for the drive computation, taken after the tuning update
	typedef struct packed {
		logic signed [31:0] gp;
		logic signed [31:0] gd;
		logic signed [31:0] gi;
		logic signed [15:0] err;
		logic signed [16:0] delta;
		logic signed [31:0] esum;
		logic               run_ok;
		logic               active;
	} drive_ops_t;

endpackage

/* sv/pwtt_cfg.sv */
module pwtt_cfg import pwtt_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output cfg_regs_t   regs,
	output logic        reinit
);

	cfg_regs_t regs_q;
	logic      reinit_q;
	logic      wr;

	assign wr = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.kp      <= RST_KP;
			regs_q.ki      <= RST_KI;
			regs_q.kd      <= RST_KD;
			regs_q.step_p  <= RST_STEP_P;
			regs_q.step_d  <= RST_STEP_D;
			regs_q.step_i  <= RST_STEP_I;
			regs_q.best    <= RST_BEST;
			regs_q.run_len <= RST_RUN;
			reinit_q       <= 1'b0;
		end else begin
			reinit_q <= wr;
			if (wr) begin
				case (reg_index_t'(paddr[4:2]))
					REG_KP:     regs_q.kp      <= pwdata;
					REG_KI:     regs_q.ki      <= pwdata;
					REG_KD:     regs_q.kd      <= pwdata;
					REG_STEP_P: regs_q.step_p  <= pwdata[30:0];
					REG_STEP_D: regs_q.step_d  <= pwdata[30:0];
					REG_STEP_I: regs_q.step_i  <= pwdata[30:0];
					REG_BEST:   regs_q.best    <= pwdata[15:0];
					REG_RUN:    regs_q.run_len <= pwdata[15:0];
					default:    regs_q         <= regs_q;
				endcase
			end
		end
	end

	always_comb begin
		case (reg_index_t'(paddr[4:2]))
			REG_KP:     prdata = regs_q.kp;
			REG_KI:     prdata = regs_q.ki;
			REG_KD:     prdata = regs_q.kd;
			REG_STEP_P: prdata = {1'b0, regs_q.step_p};
			REG_STEP_D: prdata = {1'b0, regs_q.step_d};
			REG_STEP_I: prdata = {1'b0, regs_q.step_i};
			REG_BEST:   prdata = {{16{regs_q.best[15]}}, regs_q.best};
			REG_RUN:    prdata = {16'd0, regs_q.run_len};
			default:    prdata = 32'd0;
		endcase
	end

	assign regs   = regs_q;
	assign reinit = reinit_q;

endmodule

/* sv/pwtt_tune.sv */
`include "pid_with_twiddle_tuning_top_assert.svh"

module pwtt_tune import pwtt_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  cfg_regs_t          regs,
	input  logic               reinit,
	input  logic               upd,
	input  logic signed [15:0] sample,
	output drive_ops_t         ops
);

	typedef enum logic [1:0] {
		OP_PROBE   = 2'd0,
		OP_REVERSE = 2'd1,
		OP_BACKOFF = 2'd2
	} twiddle_op_t;

	localparam logic [3:0]  LAST_PHASE     = 4'd8;
	localparam logic [32:0] STEP_THRESHOLD = 33'd167;
	localparam logic [30:0] STEP_MAX       = 31'h7fff_ffff;
	// x / 10 == (x * RECIP10) >> 35 for any 32-bit x
	localparam logic [63:0] RECIP10        = 64'h0000_0000_cccc_cccd;

	logic signed [15:0] last_q;
	logic signed [31:0] esum_q;
	logic signed [31:0] gain_q [3];
	logic [30:0]        step_q [3];
	logic signed [15:0] best_q;
	logic [3:0]         phase_q;
	logic [15:0]        cnt_q;

	logic [3:0]         phase_n;
	logic [15:0]        cnt_n;
	logic signed [32:0] esum_w;
	logic signed [31:0] esum_n;
	logic               active;
	logic [1:0]         grp;
	twiddle_op_t        op;
	logic signed [31:0] g_sel;
	logic [30:0]        s_sel;
	logic               better;
	logic               worse;
	logic               do_gain;
	logic               neg2;
	logic               do_grow;
	logic               do_shrink;
	logic signed [33:0] addend;
	logic signed [33:0] gsum;
	logic signed [31:0] g_new;
	logic [31:0]        div_in;
	logic [63:0]        div_prod;
	logic [28:0]        div_q;
	logic [31:0]        grown;
	logic [30:0]        s_new;
	logic signed [31:0] gain_nx [3];

	assign phase_n = (phase_q == LAST_PHASE) ? 4'd0 : phase_q + 4'd1;
	assign cnt_n   = (&cnt_q) ? cnt_q : cnt_q + 16'd1;
	assign esum_w  = 33'(esum_q) + 33'(sample);
	assign esum_n  = (esum_w[32] != esum_w[31]) ?
		(esum_w[32] ? 32'sh8000_0000 : 32'sh7fff_ffff) : esum_w[31:0];
	assign active  = ({2'b00, step_q[0]} + {2'b00, step_q[1]} + {2'b00, step_q[2]})
		> STEP_THRESHOLD;

	always_comb begin
		case (phase_n)
			4'd1: begin grp = 2'd0; op = OP_PROBE; end
			4'd2: begin grp = 2'd0; op = OP_REVERSE; end
			4'd3: begin grp = 2'd0; op = OP_BACKOFF; end
			4'd4: begin grp = 2'd1; op = OP_PROBE; end
			4'd5: begin grp = 2'd1; op = OP_REVERSE; end
			4'd6: begin grp = 2'd1; op = OP_BACKOFF; end
			4'd7: begin grp = 2'd2; op = OP_PROBE; end
			4'd8: begin grp = 2'd2; op = OP_REVERSE; end
			default: begin grp = 2'd2; op = OP_BACKOFF; end
		endcase
	end

	assign g_sel  = gain_q[grp];
	assign s_sel  = step_q[grp];
	assign better = sample < best_q;
	assign worse  = sample > best_q;

	always_comb begin
		do_gain   = 1'b0;
		neg2      = 1'b0;
		do_grow   = 1'b0;
		do_shrink = 1'b0;
		case (op)
			OP_PROBE: do_gain = 1'b1;
			OP_REVERSE: begin
				do_grow = better;
				do_gain = !better;
				neg2    = 1'b1;
			end
			OP_BACKOFF: begin
				do_grow   = better;
				do_gain   = worse;
				do_shrink = worse;
			end
			default: do_gain = 1'b0;
		endcase
	end

	// gain += step, or gain -= 2*step, saturated
	assign addend = neg2 ? -($signed({2'b00, s_sel, 1'b0})) : $signed({3'b000, s_sel});
	assign gsum   = 34'(g_sel) + addend;
	assign g_new  = (gsum[33:31] == 3'b000 || gsum[33:31] == 3'b111) ? gsum[31:0] :
		(gsum[33] ? 32'sh8000_0000 : 32'sh7fff_ffff);

	// round(step*1.1) = step + (step+5)/10, round(step*0.9) = step - (step+4)/10
	assign div_in   = {1'b0, s_sel} + (do_grow ? 32'd5 : 32'd4);
	assign div_prod = {32'd0, div_in} * RECIP10;
	assign div_q    = div_prod[63:35];
	assign grown    = {1'b0, s_sel} + {3'b000, div_q};
	assign s_new    = do_grow ? (grown[31] ? STEP_MAX : grown[30:0]) :
		(s_sel - {2'b00, div_q});

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			gain_nx[k] = (active && do_gain && grp == 2'(k)) ? g_new : gain_q[k];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q    <= '0;
			esum_q    <= '0;
			gain_q[0] <= RST_KP;
			gain_q[1] <= RST_KD;
			gain_q[2] <= RST_KI;
			step_q[0] <= RST_STEP_P;
			step_q[1] <= RST_STEP_D;
			step_q[2] <= RST_STEP_I;
			best_q    <= RST_BEST;
			phase_q   <= '0;
			cnt_q     <= '0;
		end else if (reinit) begin
			last_q    <= '0;
			esum_q    <= '0;
			gain_q[0] <= regs.kp;
			gain_q[1] <= regs.kd;
			gain_q[2] <= regs.ki;
			step_q[0] <= regs.step_p;
			step_q[1] <= regs.step_d;
			step_q[2] <= regs.step_i;
			best_q    <= regs.best;
			phase_q   <= '0;
			cnt_q     <= '0;
		end else if (upd) begin
			last_q  <= sample;
			esum_q  <= esum_n;
			phase_q <= phase_n;
			cnt_q   <= cnt_n;
			if (active) begin
				if (do_gain) begin
					gain_q[grp] <= g_new;
				end
				if (do_grow || do_shrink) begin
					step_q[grp] <= s_new;
				end
				if (do_grow) begin
					best_q <= sample;
				end
			end
		end
	end

	always_comb begin
		ops.gp     = gain_nx[0];
		ops.gd     = gain_nx[1];
		ops.gi     = gain_nx[2];
		ops.err    = sample;
		ops.delta  = 17'(sample) - 17'(last_q);
		ops.esum   = esum_n;
		ops.run_ok = cnt_n < regs.run_len;
		ops.active = active;
	end

	`PWTT_ASSERT_NEXT(a_cnt_moves, upd && !reinit, cnt_q != 16'd0, "step count stuck at zero")
	`PWTT_ASSERT_NEXT(a_idle_gains, upd && !reinit && !active, $stable(gain_q[0]) && $stable(gain_q[1]) && $stable(gain_q[2]), "gain moved while tuning idle")
	`PWTT_ASSERT_IMPL(a_phase_range, 1'b1, phase_q <= LAST_PHASE, "phase out of range")

endmodule

/* sv/pwtt_drive.sv */
`include "pid_with_twiddle_tuning_top_assert.svh"

module pwtt_drive import pwtt_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  drive_ops_t         ops,
	input  logic               upd,
	output logic               s1_free,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] drive_value,
	output logic               tuning_active
);

	logic               v1_s1, v2_s2, v3_q;
	logic               en2, en3;
	drive_ops_t         ops_s1;
	logic signed [47:0] prod_p_s2;
	logic signed [48:0] prod_d_s2;
	logic signed [63:0] prod_i_s2;
	logic               run_ok_s2, active_s2;
	logic signed [65:0] total;
	logic signed [65:0] rnd;
	logic signed [65:0] shr;
	logic signed [31:0] sat;
	logic signed [31:0] drive_q;
	logic               active_q;

	assign en3     = !v3_q || out_ready;
	assign en2     = !v2_s2 || en3;
	assign s1_free = !v1_s1 || en2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_s1 <= 1'b0;
			v2_s2 <= 1'b0;
			v3_q  <= 1'b0;
		end else begin
			if (s1_free) v1_s1 <= upd;
			if (en2)     v2_s2 <= v1_s1;
			if (en3)     v3_q  <= v2_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_free && upd) begin
			ops_s1 <= ops;
		end
		if (en2 && v1_s1) begin
			prod_p_s2 <= 48'(ops_s1.gp) * 48'(ops_s1.err);
			prod_d_s2 <= 49'(ops_s1.gd) * 49'(ops_s1.delta);
			prod_i_s2 <= 64'(ops_s1.gi) * 64'(ops_s1.esum);
			run_ok_s2 <= ops_s1.run_ok;
			active_s2 <= ops_s1.active;
		end
		if (en3 && v2_s2) begin
			drive_q  <= run_ok_s2 ? sat : 32'sd0;
			active_q <= active_s2;
		end
	end

	// negate Q16.32 sum, round half up to Q16.16, saturate
	assign total = 66'(prod_p_s2) + 66'(prod_d_s2) + 66'(prod_i_s2);
	assign rnd   = -total + 66'sd32768;
	assign shr   = rnd >>> 16;
	assign sat   = (&shr[65:31] || ~|shr[65:31]) ? shr[31:0] :
		(shr[65] ? 32'sh8000_0000 : 32'sh7fff_ffff);

	assign out_valid     = v3_q;
	assign drive_value   = drive_q;
	assign tuning_active = active_q;

	`PWTT_ASSERT_NEXT(a_no_extra, out_valid && out_ready && !v2_s2, !out_valid, "beat without a source")
	`PWTT_ASSERT_NEXT(a_run_done, v2_s2 && en3 && !run_ok_s2, drive_value == 32'sd0, "drive after run end")

endmodule

/* sv/pid_with_twiddle_tuning_top.sv */
// PID controller with twiddle self-tuning. Takes one Q8.8 error sample per
// beat and returns one beat with the Q16.16 drive and the tuning flag. A new
// sample is accepted every cycle while results are taken; a result is presented
// after its sample passes the input register, then the tuning update into the
// operand register, the three gain multiplies and the round and saturate, each
// registered in turn.
// The rate is set by the twiddle update of gains, steps and best error, which
// closes on itself. Any register write reloads the whole tuning state from the
// registers in the cycle after the write.
module pid_with_twiddle_tuning_top import pwtt_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [4:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [15:0] error_sample,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] drive_value,
	output logic               tuning_active
);

	cfg_regs_t          regs;
	logic               reinit;
	drive_ops_t         ops;
	logic               s1_free;
	logic               v0_s0;
	logic signed [15:0] err_s0;
	logic               upd;

	assign pready   = 1'b1;
	assign in_ready = !v0_s0 || s1_free;
	assign upd      = v0_s0 && s1_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v0_s0 <= 1'b0;
		end else if (in_ready) begin
			v0_s0 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			err_s0 <= error_sample;
		end
	end

	pwtt_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.regs    (regs),
		.reinit  (reinit)
	);

	pwtt_tune u_tune (
		.clk    (clk),
		.arst_n (arst_n),
		.regs   (regs),
		.reinit (reinit),
		.upd    (upd),
		.sample (err_s0),
		.ops    (ops)
	);

	pwtt_drive u_drive (
		.clk           (clk),
		.arst_n        (arst_n),
		.ops           (ops),
		.upd           (upd),
		.s1_free       (s1_free),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.drive_value   (drive_value),
		.tuning_active (tuning_active)
	);

endmodule

/* verif/pid_with_twiddle_tuning_top_tb.sv */
module pid_with_twiddle_tuning_top_tb import pwtt_pkg::*;;

	localparam logic signed [31:0] GAIN_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [31:0] GAIN_MIN = 32'sh8000_0000;
	localparam logic [30:0]        STEP_MAX = 31'h7FFF_FFFF;
	localparam int                 STEP_THRESHOLD = 167;
	localparam int                 NUM_PHASES = 9;
	localparam int                 IDX_P = 0;
	localparam int                 IDX_D = 1;
	localparam int                 IDX_I = 2;
	localparam int                 SUB_PROBE = 0;
	localparam int                 SUB_REVERSE = 1;
	localparam int                 SUB_BACKOFF = 2;

	typedef struct packed {
		logic signed [31:0] drive;
		logic               active;
	} pid_result_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               psel = 1'b0;
	logic               penable = 1'b0;
	logic               pwrite = 1'b0;
	logic [4:0]         paddr = '0;
	logic [31:0]        pwdata = '0;
	logic [31:0]        prdata;
	logic               pready;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic signed [15:0] error_sample = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic signed [31:0] drive_value;
	logic               tuning_active;

	pid_with_twiddle_tuning_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.error_sample(error_sample),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.drive_value(drive_value),
		.tuning_active(tuning_active)
	);

	// controller model state
	cfg_regs_t          cfg;
	logic signed [15:0] prev_err;
	logic signed [16:0] err_delta;
	logic signed [31:0] err_sum;
	logic signed [31:0] gain_q [3];
	logic [30:0]        step_q [3];
	logic signed [15:0] best_seen;
	int                 phase_q;
	logic [15:0]        step_count;

	pid_result_t        expected_drive_q[$];

	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int error_count = 0;
	int beats_checked = 0;
	int beats_tuning = 0;
	int beats_sent = 0;
	int reg_writes = 0;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	initial begin
		#2000000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	function automatic logic signed [31:0] clamp32(longint v);
		if (v > longint'(GAIN_MAX))
			return GAIN_MAX;
		if (v < longint'(GAIN_MIN))
			return GAIN_MIN;
		return v[31:0];
	endfunction

	function automatic logic [30:0] scale_step(logic [30:0] s, int unsigned num);
		longint unsigned r;
		r = (longint'(s) * num + 5) / 10;
		return (r > longint'(STEP_MAX)) ? STEP_MAX : r[30:0];
	endfunction

	function automatic void reload_state();
		prev_err = '0;
		err_delta = '0;
		err_sum = '0;
		gain_q[IDX_P] = cfg.kp;
		gain_q[IDX_D] = cfg.kd;
		gain_q[IDX_I] = cfg.ki;
		step_q[IDX_P] = cfg.step_p;
		step_q[IDX_D] = cfg.step_d;
		step_q[IDX_I] = cfg.step_i;
		best_seen = cfg.best;
		phase_q = 0;
		step_count = '0;
	endfunction

	function automatic void apply_reg(reg_index_t idx, logic [31:0] val);
		case (idx)
			REG_KP: cfg.kp = val;
			REG_KI: cfg.ki = val;
			REG_KD: cfg.kd = val;
			REG_STEP_P: cfg.step_p = val[30:0];
			REG_STEP_D: cfg.step_d = val[30:0];
			REG_STEP_I: cfg.step_i = val[30:0];
			REG_BEST: cfg.best = val[15:0];
			REG_RUN: cfg.run_len = val[15:0];
			default: ;
		endcase
		reload_state();
	endfunction

	function automatic void predict_drive(logic signed [15:0] e);
		longint unsigned sum;
		longint acc;
		bit active;
		int g;
		int sub;
		pid_result_t r;
		err_delta = 17'(longint'(e) - longint'(prev_err));
		prev_err = e;
		err_sum = clamp32(longint'(err_sum) + longint'(e));
		if (step_count != 16'hFFFF)
			step_count++;
		phase_q = (phase_q + 1) % NUM_PHASES;
		sum = longint'(step_q[IDX_P]) + longint'(step_q[IDX_D]) + longint'(step_q[IDX_I]);
		active = (sum > STEP_THRESHOLD);
		if (active) begin
			g = (phase_q == 0) ? IDX_I : (phase_q - 1) / 3;
			sub = (phase_q == 0) ? SUB_BACKOFF : (phase_q - 1) % 3;
			case (sub)
				SUB_PROBE: gain_q[g] = clamp32(longint'(gain_q[g]) + longint'(step_q[g]));
				SUB_REVERSE: begin
					if (e < best_seen) begin
						best_seen = e;
						step_q[g] = scale_step(step_q[g], 11);
					end else begin
						gain_q[g] = clamp32(longint'(gain_q[g]) - 2 * longint'(step_q[g]));
					end
				end
				default: begin
					if (e < best_seen) begin
						best_seen = e;
						step_q[g] = scale_step(step_q[g], 11);
					end else if (e > best_seen) begin
						gain_q[g] = clamp32(longint'(gain_q[g]) + longint'(step_q[g]));
						step_q[g] = scale_step(step_q[g], 9);
					end
				end
			endcase
		end
		r.drive = '0;
		if (step_count < cfg.run_len) begin
			acc = longint'(gain_q[IDX_P]) * longint'(e)
				+ longint'(gain_q[IDX_D]) * longint'(err_delta)
				+ longint'(gain_q[IDX_I]) * longint'(err_sum);
			acc = -acc;
			r.drive = clamp32((acc + 32768) >>> 16);
		end
		r.active = active;
		expected_drive_q.push_back(r);
	endfunction

	task automatic report_mismatch(string msg);
		$display("MISMATCH @%0t: %s", $realtime, msg);
		error_count++;
	endtask

	// receiver stall pattern
	always @(negedge clk)
		out_ready <= ($urandom_range(99) >= recv_idle_pct);

	always @(posedge clk) begin
		pid_result_t exp_r;
		if (arst_n && out_valid && out_ready) begin
			if (expected_drive_q.size() == 0) begin
				report_mismatch($sformatf("unexpected beat drive=%0d active=%0b",
					drive_value, tuning_active));
			end else begin
				exp_r = expected_drive_q.pop_front();
				beats_checked++;
				if (exp_r.active)
					beats_tuning++;
				if (drive_value !== exp_r.drive)
					report_mismatch($sformatf("beat %0d drive_value %0d, want %0d",
						beats_checked, drive_value, exp_r.drive));
				if (tuning_active !== exp_r.active)
					report_mismatch($sformatf("beat %0d tuning_active %0b, want %0b",
						beats_checked, tuning_active, exp_r.active));
			end
		end
	end

	// called at a falling edge, returns at a falling edge
	task automatic send_sample(logic signed [15:0] s);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid = 1'b1;
		error_sample = s;
		do
			@(posedge clk);
		while (!in_ready);
		predict_drive(s);
		beats_sent++;
		@(negedge clk);
	endtask

	task automatic write_reg(reg_index_t idx, logic [31:0] val);
		psel = 1'b1;
		penable = 1'b0;
		pwrite = 1'b1;
		paddr = {idx, 2'b00};
		pwdata = val;
		@(negedge clk);
		penable = 1'b1;
		do
			@(posedge clk);
		while (!pready);
		apply_reg(idx, val);
		reg_writes++;
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
	endtask

	task automatic drain();
		in_valid = 1'b0;
		while (expected_drive_q.size() != 0)
			@(negedge clk);
	endtask

	task automatic configure(logic [31:0] kp, logic [31:0] ki, logic [31:0] kd,
		logic [30:0] sp, logic [30:0] sd, logic [30:0] si,
		logic [15:0] best, logic [15:0] run_len);
		drain();
		repeat (8) @(negedge clk);
		write_reg(REG_KP, kp);
		write_reg(REG_KI, ki);
		write_reg(REG_KD, kd);
		write_reg(REG_STEP_P, {1'b0, sp});
		write_reg(REG_STEP_D, {1'b0, sd});
		write_reg(REG_STEP_I, {1'b0, si});
		write_reg(REG_BEST, {16'h0, best});
		write_reg(REG_RUN, {16'h0, run_len});
		repeat (4) @(negedge clk);
	endtask

	function automatic logic [31:0] rand_gain();
		case ($urandom_range(9))
			0: return '0;
			1: return GAIN_MAX;
			2: return GAIN_MIN;
			3, 4: return $urandom;
			default: return 32'($signed($urandom_range(0, 32'h0400_0000)) - 32'sh0200_0000);
		endcase
	endfunction

	function automatic logic [30:0] rand_step();
		case ($urandom_range(7))
			0: return '0;
			1: return STEP_MAX;
			2: return 31'($urandom_range(0, 300));
			3: return 31'($urandom);
			default: return 31'($urandom_range(0, 32'h0100_0000));
		endcase
	endfunction

	function automatic logic [15:0] rand_best();
		case ($urandom_range(5))
			0: return 16'h8000;
			1: return 16'h7FFF;
			2, 3: return 16'($urandom);
			default: return 16'($signed($urandom_range(0, 1023)) - 512);
		endcase
	endfunction

	function automatic logic [15:0] rand_run();
		case ($urandom_range(7))
			0: return '0;
			1, 2: return 16'hFFFF;
			3: return 16'($urandom_range(1, 50));
			default: return 16'($urandom_range(200, 65535));
		endcase
	endfunction

	function automatic logic signed [15:0] rand_sample();
		case ($urandom_range(19))
			0: return 16'sh8000;
			1: return 16'sh7FFF;
			2, 3: return best_seen;
			4, 5, 6, 7, 8: return 16'($urandom);
			default: return 16'($signed($urandom_range(0, 1023)) - 512);
		endcase
	endfunction

	task automatic test_reset_defaults();
		logic signed [15:0] vals [6] = '{16'sd0, 16'sh7FFF, 16'sh8000, 16'sd256, 16'sd255, -16'sd1};
		foreach (vals[i])
			send_sample(vals[i]);
	endtask

	// probe, reverse and back-off outcomes for each gain, ties included
	task automatic test_twiddle_branches();
		logic signed [15:0] vals [9] = '{16'sd0, 16'sd100, 16'sd100, 16'sd50, 16'sd20,
			16'sd30, 16'sd0, 16'sd10, 16'sd10};
		configure(32'h0100_0000, 32'h0008_0000, 32'hFF80_0000,
			31'd200000, 31'd1000000, 31'd5000, 16'sd100, 16'd1000);
		foreach (vals[i])
			send_sample(vals[i]);
	endtask

	// gains and steps pinned at their limits
	task automatic test_saturation();
		logic signed [15:0] vals [6] = '{16'sh7FFF, 16'sh8000, 16'sd0, 16'sh7FFF,
			16'sd5, 16'sh8000};
		configure(GAIN_MAX, GAIN_MAX, GAIN_MIN, STEP_MAX, STEP_MAX, STEP_MAX,
			16'sh7FFF, 16'hFFFF);
		foreach (vals[i])
			send_sample(vals[i]);
	endtask

	// step sum right at and just above the threshold, short runs
	task automatic test_threshold_and_run_end();
		configure(32'h0200_0000, 32'h0000_1000, 32'h0080_0000,
			31'd100, 31'd60, 31'd7, 16'sd256, 16'd2);
		send_sample(16'sd300);
		send_sample(-16'sd300);
		send_sample(16'sd40);
		configure(32'h0200_0000, 32'h0000_1000, 32'h0080_0000,
			31'd100, 31'd60, 31'd8, 16'sd256, 16'd0);
		send_sample(16'sd300);
		send_sample(-16'sd300);
		send_sample(16'sd40);
	endtask

	task automatic test_random(int n_items, int s_idle, int r_idle);
		send_idle_pct = s_idle;
		recv_idle_pct = r_idle;
		for (int i = 0; i < n_items; i++) begin
			if (i % 120 == 0)
				configure(rand_gain(), rand_gain(), rand_gain(), rand_step(), rand_step(),
					rand_step(), rand_best(), rand_run());
			send_sample(rand_sample());
		end
	endtask

	// full-scale stream sent back to back
	task automatic test_long_run();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		configure(32'h0000_0100, 32'h0000_0001, 32'h0000_0040,
			31'd1000, 31'd2000, 31'd500, 16'sd256, 16'hFFFF);
		repeat (24)
			send_sample(16'sh7FFF);
		repeat (6)
			send_sample(16'sh8000);
	endtask

	initial begin
		cfg = '{kp: RST_KP, ki: RST_KI, kd: RST_KD, step_p: RST_STEP_P,
			step_d: RST_STEP_D, step_i: RST_STEP_I, best: RST_BEST, run_len: RST_RUN};
		reload_state();
		repeat (12) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		send_idle_pct = 37;
		recv_idle_pct = 57;
		test_reset_defaults();
		test_twiddle_branches();
		test_saturation();
		test_threshold_and_run_end();
		test_random(350, 37, 57);
		test_random(350, 57, 37);
		test_random(350, 0, 0);
		test_long_run();

		drain();
		repeat (20) @(negedge clk);

		$display("Sent %0d samples over %0d register writes; %0d beats checked, %0d with tuning.",
			beats_sent, reg_writes, beats_checked, beats_tuning);
		$display("Covered twiddle branches, gain/step saturation, threshold, run end, full-scale stream.");
		if (error_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

/* sim.f */
+incdir+sv
sv/pwtt_pkg.sv
sv/pwtt_cfg.sv
sv/pwtt_tune.sv
sv/pwtt_drive.sv
sv/pid_with_twiddle_tuning_top.sv
verif/pid_with_twiddle_tuning_top_tb.sv
